// ===== design/fyp_pkg.sv =====
// ----------------------------------------------------------------------------
// fyp_pkg: shared types and constants for the permutation generator
// Sizes, store request words and the remainder unit result word.
// ----------------------------------------------------------------------------
package fyp_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int IDX_W    = 10;           // position / element width
  localparam int SIZE_W   = 11;           // perm_size register width
  localparam int WORD_W   = 64;           // random word width
  localparam int CNT_W    = $clog2(WORD_W);

  localparam logic [SIZE_W-1:0] PERM_SIZE_RESET = SIZE_W'(MAX_SIZE);

  // store write request: mark set means the entry holds a shuffled value
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             mark;
    logic [IDX_W-1:0] value;
  } store_wr_t;

  // store read request: both entries of one swap
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr_i;
    logic [IDX_W-1:0] addr_j;
  } store_rd_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_res_t;

  // size actually used: zero counts as one, anything above the maximum clamps
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    if (s > SIZE_W'(MAX_SIZE)) r = SIZE_W'(MAX_SIZE);
    return r;
  endfunction

endpackage

// ===== design/fyp_ifs.sv =====
// ----------------------------------------------------------------------------
// fyp_ifs: valid/ready channels of the permutation generator
// Random word input, result output and the size write channel.
// ----------------------------------------------------------------------------
interface fyp_word_if;
  import fyp_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;
  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface fyp_result_if;
  import fyp_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] position;
  logic [IDX_W-1:0] element;
  logic             last;
  modport source (output valid, output position, output element, output last,
                  input ready);
  modport sink   (input valid, input position, input element, input last,
                  output ready);
endinterface

interface fyp_cfg_if;
  import fyp_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] perm_size;
  modport source (output valid, output perm_size, input ready);
  modport sink   (input valid, input perm_size, output ready);
endinterface

// ===== design/fyp_rem_unit.sv =====
// ----------------------------------------------------------------------------
// fyp_rem_unit: bit-serial remainder of a 64-bit word by a small divisor
// Restoring shift/compare/subtract, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module fyp_rem_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fyp_pkg::WORD_W-1:0]    dividend,
  input  logic [fyp_pkg::SIZE_W-1:0]    divisor,
  output fyp_pkg::div_res_t             res
);
  import fyp_pkg::*;

  logic [WORD_W-1:0] word;
  logic [SIZE_W-1:0] dvs;
  logic [IDX_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [SIZE_W-1:0] rem_sh;
  logic [SIZE_W-1:0] rem_next;

  // remainder stays below the divisor, so it fits the index width
  always_comb begin
    rem_sh   = {rem, word[WORD_W-1]};
    rem_next = (rem_sh >= dvs) ? rem_sh - dvs : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(WORD_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WORD_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      word <= {word[WORD_W-2:0], 1'b0};
      rem  <= rem_next[IDX_W-1:0];
    end
  end

  assign res.done = done;
  assign res.rem  = rem;

endmodule

// ===== design/fyp_store.sv =====
// ----------------------------------------------------------------------------
// fyp_store: permutation entry store with touched marks
// One write port, two registered read ports; an unmarked entry reads as
// its own index.
// ----------------------------------------------------------------------------
module fyp_store (
  input  logic                      clk,
  input  fyp_pkg::store_wr_t        wr,
  input  fyp_pkg::store_rd_t        rd,
  output logic [fyp_pkg::IDX_W-1:0] val_i,
  output logic [fyp_pkg::IDX_W-1:0] val_j
);
  import fyp_pkg::*;

  logic [IDX_W:0]   mem [MAX_SIZE];
  logic [IDX_W:0]   q_i;
  logic [IDX_W:0]   q_j;
  logic [IDX_W-1:0] a_i;
  logic [IDX_W-1:0] a_j;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= {wr.mark, wr.value};
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      q_i <= mem[rd.addr_i];
      q_j <= mem[rd.addr_j];
      a_i <= rd.addr_i;
      a_j <= rd.addr_j;
    end
  end

  assign val_i = q_i[IDX_W] ? q_i[IDX_W-1:0] : a_i;
  assign val_j = q_j[IDX_W] ? q_j[IDX_W-1:0] : a_j;

endmodule

// ===== design/fisher_yates_permutation.sv =====
// ----------------------------------------------------------------------------
// fisher_yates_permutation: random permutation generator, downward walk
// Each random word drives one swap step and yields one result word.
// ----------------------------------------------------------------------------
// words   : one 64-bit random word per step, taken while ready is high.
// results : position (descending from perm_size-1), the element now final at
//           it, and last on position 0; the next word then starts a new run.
// cfg     : writes perm_size (0 counts as 1, above 1024 clamps to 1024) and
//           restarts the run. Only write while no step is outstanding.
// Timing  : a step holds the block from acceptance to result: first the
//           bit-serial remainder unit, then one store read and two store
//           writes through its single write port. Words are taken one at a
//           time, the next only once the last step's result is loaded.
// Run start: after reset, a size write or the last result, a clearing pass
//           walks the touched marks of entries 0..size-1, one a cycle;
//           words are not taken meanwhile.
// Stall   : the result sits in an output register; the next word is taken
//           while it waits, and that step holds in its final write until the
//           register is free.
// ----------------------------------------------------------------------------
module fisher_yates_permutation (
  input  logic          clk,
  input  logic          rst,
  fyp_word_if.sink      words,
  fyp_result_if.source  results,
  fyp_cfg_if.sink       cfg
);
  import fyp_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_WR1   = 3'd3;
  localparam logic [2:0] S_WR2   = 3'd4;

  logic [2:0]        state;
  logic [SIZE_W-1:0] perm_size;
  logic [SIZE_W-1:0] clr_idx;
  logic [IDX_W-1:0]  step;
  logic [IDX_W-1:0]  j_sel;

  logic              out_valid;
  logic [IDX_W-1:0]  out_pos;
  logic [IDX_W-1:0]  out_elem;
  logic              out_last;

  logic [SIZE_W-1:0] size_eff;
  logic [SIZE_W-1:0] size_m1;
  logic              in_acc;
  logic              cfg_acc;
  logic              load;

  store_wr_t         wr;
  store_rd_t         rd;
  div_res_t          div_res;
  logic [IDX_W-1:0]  val_i;
  logic [IDX_W-1:0]  val_j;

  assign size_eff = eff_size(perm_size);
  assign size_m1  = size_eff - SIZE_W'(1);

  assign words.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc      = words.valid && words.ready;
  assign cfg_acc     = cfg.valid && cfg.ready;
  assign load        = (state == S_WR2) && (!out_valid || results.ready);

  fyp_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .dividend (words.random_word),
    .divisor  (SIZE_W'(step) + SIZE_W'(1)),
    .res      (div_res)
  );

  fyp_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .val_i (val_i),
    .val_j (val_j)
  );

  always_comb begin
    wr = '0;
    rd = '0;
    unique case (state)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_idx[IDX_W-1:0];
      end
      S_DIV: begin
        rd.en     = div_res.done;
        rd.addr_i = step;
        rd.addr_j = div_res.rem;
      end
      S_WR1: begin
        wr.en    = 1'b1;
        wr.addr  = step;
        wr.mark  = 1'b1;
        wr.value = val_j;
      end
      S_WR2: begin
        // rewritten every stalled cycle with the same value
        wr.en    = 1'b1;
        wr.addr  = j_sel;
        wr.mark  = 1'b1;
        wr.value = val_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      perm_size <= PERM_SIZE_RESET;
      clr_idx   <= '0;
      step      <= '0;
    end else if (cfg_acc) begin
      perm_size <= cfg.perm_size;
      state     <= S_CLEAR;
      clr_idx   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + SIZE_W'(1);
          if (clr_idx == size_m1) begin
            state <= S_IDLE;
            step  <= size_m1[IDX_W-1:0];
          end
        end
        S_IDLE: begin
          if (in_acc) state <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) state <= S_WR1;
        end
        S_WR1: state <= S_WR2;
        S_WR2: begin
          if (load) begin
            if (step == '0) begin
              state   <= S_CLEAR;
              clr_idx <= '0;
            end else begin
              state <= S_IDLE;
              step  <= step - IDX_W'(1);
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_res.done) j_sel <= div_res.rem;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pos  <= step;
      out_elem <= val_j;
      out_last <= (step == '0);
    end
  end

  assign results.valid    = out_valid;
  assign results.position = out_pos;
  assign results.element  = out_elem;
  assign results.last     = out_last;

`ifndef ASSERT_OFF
  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_res.done) |-> (div_res.rem <= step))
    else $error("swap partner beyond step position");

  a_step_in_size: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (SIZE_W'(step) < size_eff))
    else $error("step position outside permutation size");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (load && step == '0 && !cfg_acc) |=> (state == S_CLEAR))
    else $error("no clearing pass after last word");

  a_last_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.last) |-> (results.position == '0))
    else $error("last flagged away from position zero");
`endif

endmodule
